// ----- design/lpbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpbp_pkg
// Shared constants and types of the page buffer pool tag manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbp_pkg;

  // pool geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int PAGE_W  = 32;
  localparam int STAMP_W = 32;
  localparam int REFS_W  = 8;

  // request opcodes
  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DIRTY   = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // replacement candidate handed from cell to cell
  typedef struct packed {
    logic                 found;
    slot_idx_t            idx;
    logic [STAMP_W-1:0]   stamp;
    logic                 wb;
    logic [PAGE_W-1:0]    page;
  } cand_t;

  // slot update broadcast to the row of cells
  typedef struct packed {
    logic                 en;
    slot_idx_t            idx;
    logic                 wr_refs;
    logic                 wr_stamp;
    logic                 set_dirty;
    logic                 install;
    logic [REFS_W-1:0]    refs;
    logic [STAMP_W-1:0]   stamp;
    logic [PAGE_W-1:0]    page;
  } upd_t;

endpackage

`default_nettype wire

// ----- design/lru_page_buffer_pool_unit.sv -----
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_unit
// Tag manager of a page buffer pool with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_opcode, in_page_number) is taken at a clock edge where
//   start is high and busy is low. Each request yields exactly one result
//   beat on the out_ ports, marked by out_valid for a single cycle; the
//   receiver must take it then.
//   Slots sit in a row of cells. Every cell compares its tag with the
//   request in parallel, and a replacement candidate ripples through the
//   row one cell per clock.
// Sequence:
//   Release, mark dirty, lookup and acquire hits resolve on the tag compare
//   in the search state, and the result is registered onto the out_ ports.
//   Acquire misses wait in the search state for the candidate to cross the
//   row. busy is high from the accepting edge to the result beat, so a
//   request can be accepted in the cycle the previous result is shown.
// Reset:
//   Synchronous rst_n empties every slot and clears stamps and counts;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_buffer_pool_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [1:0]                    in_opcode,
  input  wire [lpbp_pkg::PAGE_W-1:0]   in_page_number,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [3:0]                   out_slot_index,
  output logic                         out_writeback_needed,
  output logic [lpbp_pkg::PAGE_W-1:0]  out_writeback_page,
  output logic [lpbp_pkg::REFS_W-1:0]  out_references
);
  import lpbp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic               state_r, state_nxt;
  slot_idx_t          cnt_r,   cnt_nxt;
  logic [1:0]         op_r;
  logic [PAGE_W-1:0]  page_r;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;

  logic                out_valid_r;
  logic [1:0]          status_r,  status_nxt;
  logic [3:0]          slot_r,    slot_nxt;
  logic                wb_r,      wb_nxt;
  logic [PAGE_W-1:0]   wbpage_r,  wbpage_nxt;
  logic [REFS_W-1:0]   refs_out_r, refs_out_nxt;

  cand_t              cand_chain [SLOTS+1];
  logic [SLOTS-1:0]   hit_vec;
  logic [REFS_W-1:0]  refs_vec [SLOTS];
  upd_t               upd;

  logic               accept;
  logic               decide;
  logic               hit_any;
  slot_idx_t          hit_idx;
  logic [REFS_W-1:0]  hit_refs;
  cand_t              victim;
  slot_idx_t          res_idx;
  logic [31:0]        res_idx_ext;

  assign accept = start && !busy;
  assign busy   = (state_r == S_SRCH);

  // row of slot cells
  assign cand_chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lpbp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .lk_page  (page_r),
      .upd      (upd),
      .cand_in  (cand_chain[g]),
      .cand_out (cand_chain[g+1]),
      .hit      (hit_vec[g]),
      .refs     (refs_vec[g])
    );
  end

  assign victim = cand_chain[SLOTS];

  // pick the lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign hit_refs = refs_vec[hit_idx];

  // resolve once the tag compare suffices or the candidate has crossed
  assign decide = (state_r == S_SRCH) &&
                  ((op_r != OP_ACQUIRE) || hit_any || (cnt_r == SLOT_W'(SLOTS - 1)));

  // work out the result beat and the slot update
  always_comb begin
    upd          = '0;
    stamp_nxt    = stamp_r;
    status_nxt   = ST_NOTFOUND;
    res_idx      = '0;
    wb_nxt       = 1'b0;
    wbpage_nxt   = '0;
    refs_out_nxt = '0;
    upd.page     = page_r;
    upd.stamp    = stamp_r + 1'b1;
    if (decide) begin
      if (hit_any) begin
        status_nxt   = ST_HIT;
        res_idx      = hit_idx;
        refs_out_nxt = hit_refs;
        upd.idx      = hit_idx;
        case (op_r)
          OP_ACQUIRE: begin
            upd.en       = 1'b1;
            upd.wr_refs  = 1'b1;
            upd.wr_stamp = 1'b1;
            upd.refs     = (hit_refs == REFS_MAX) ? hit_refs : hit_refs + 1'b1;
            refs_out_nxt = upd.refs;
            stamp_nxt    = stamp_r + 1'b1;
          end
          OP_RELEASE: begin
            upd.en       = 1'b1;
            upd.wr_refs  = 1'b1;
            upd.refs     = (hit_refs == '0) ? hit_refs : hit_refs - 1'b1;
            refs_out_nxt = upd.refs;
          end
          OP_DIRTY: begin
            upd.en        = 1'b1;
            upd.set_dirty = 1'b1;
          end
          default: begin
            upd.en = 1'b0;
          end
        endcase
      end else if (op_r == OP_ACQUIRE) begin
        if (victim.found) begin
          status_nxt   = ST_MISS;
          res_idx      = victim.idx;
          refs_out_nxt = REFS_W'(1);
          wb_nxt       = victim.wb;
          wbpage_nxt   = victim.wb ? victim.page : '0;
          upd.en       = 1'b1;
          upd.idx      = victim.idx;
          upd.install  = 1'b1;
          upd.refs     = REFS_W'(1);
          stamp_nxt    = stamp_r + 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
    end
  end

  assign res_idx_ext = 32'(res_idx);
  assign slot_nxt    = res_idx_ext[3:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SRCH;
          cnt_nxt   = '0;
        end
      end
      S_SRCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (decide) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= decide;
    end
  end

  // latch the request and the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      page_r <= in_page_number;
    end
    if (decide) begin
      status_r   <= status_nxt;
      slot_r     <= slot_nxt;
      wb_r       <= wb_nxt;
      wbpage_r   <= wbpage_nxt;
      refs_out_r <= refs_out_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_slot_index       = slot_r;
  assign out_writeback_needed = wb_r;
  assign out_writeback_page   = wbpage_r;
  assign out_references       = refs_out_r;

  // checks
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted request did not raise busy");

  a_wb_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback_needed) |-> (out_status == ST_MISS))
    else $error("writeback without a miss fill");

  a_miss_refs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MISS) |-> (out_references == REFS_W'(1)))
    else $error("miss fill without a count of one");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOTFOUND)) |->
      (out_slot_index == '0 && out_references == '0 && !out_writeback_needed))
    else $error("fields not cleared on pool full or not found");

endmodule

`default_nettype wire

// ----- design/lpbp_cell.sv -----
// ----------------------------------------------------------------------------
// lpbp_cell
// One pool slot: holds its tag state, compares the looked-up page and
// passes the oldest unreferenced candidate on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbp_cell (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire lpbp_pkg::slot_idx_t      cell_idx,
  input  wire [lpbp_pkg::PAGE_W-1:0]    lk_page,
  input  wire lpbp_pkg::upd_t           upd,
  input  wire lpbp_pkg::cand_t          cand_in,
  output lpbp_pkg::cand_t               cand_out,
  output logic                          hit,
  output logic [lpbp_pkg::REFS_W-1:0]   refs
);
  import lpbp_pkg::*;

  logic [PAGE_W-1:0]  page_r,  page_nxt;
  logic               valid_r, valid_nxt;
  logic               dirty_r, dirty_nxt;
  logic [REFS_W-1:0]  refs_r,  refs_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  cand_t              cand_r,  cand_nxt;
  logic               sel;
  logic               take;

  // tag compare
  assign hit  = valid_r && (page_r == lk_page);
  assign refs = refs_r;

  // apply an update aimed at this slot
  assign sel = upd.en && (upd.idx == cell_idx);

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    refs_nxt  = refs_r;
    stamp_nxt = stamp_r;
    if (sel) begin
      if (upd.install) begin
        page_nxt  = upd.page;
        valid_nxt = 1'b1;
        dirty_nxt = 1'b0;
      end
      if (upd.set_dirty) begin
        dirty_nxt = 1'b1;
      end
      if (upd.wr_refs || upd.install) begin
        refs_nxt = upd.refs;
      end
      if (upd.wr_stamp || upd.install) begin
        stamp_nxt = upd.stamp;
      end
    end
  end

  // replace the candidate when free and strictly older
  assign take = (refs_r == '0) && (!cand_in.found || (stamp_r < cand_in.stamp));

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = cell_idx;
      cand_nxt.stamp = stamp_r;
      cand_nxt.wb    = valid_r && dirty_r;
      cand_nxt.page  = page_r;
    end
  end

  assign cand_out = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      refs_r  <= '0;
      stamp_r <= '0;
      cand_r  <= '0;
    end else begin
      page_r  <= page_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      refs_r  <= refs_nxt;
      stamp_r <= stamp_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

`default_nettype wire
